// ===== hw/rtl/rbch_pkg.sv =====
// Shared constants for the ray and box closest-hit table.
// Request and status codes, default sizes and port widths.
// No dependencies.
package rbch_pkg;

    // default table depth and coordinate width
    localparam int DEF_MAX_BOXES  = 64;
    localparam int DEF_COORD_BITS = 32;

    // fixed port widths
    localparam int ID_W = 16;
    localparam int IO_W = 32;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    // request codes
    localparam t_req REQ_ADD = 2'd0;
    localparam t_req REQ_UPD = 2'd1;
    localparam t_req REQ_REM = 2'd2;
    localparam t_req REQ_RAY = 2'd3;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NFND  = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_NOHIT = 2'd3;

endpackage

// ===== hw/rtl/rbch_div.sv =====
// Bit-serial signed divider with quotient rounded toward minus infinity.
// Numerator is a slab distance scaled by 2^15, denominator a ray direction.
// Depends on rbch_pkg.
module rbch_div #(
    parameter int CW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [CW+17:0]  i_num,
    input  logic signed [CW-1:0]   i_den,
    output logic                   o_done,
    output logic signed [CW+17:0]  o_quo
);
    import rbch_pkg::*;

    localparam int MW    = CW + 17;
    localparam int QW    = MW + 1;
    localparam int CNT_W = $clog2(MW);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MW-1:0]    r_num;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_den;
    logic             r_neg;
    logic signed [QW-1:0] r_q;

    logic [MW:0]   w_num_abs;
    logic [CW-1:0] w_den_abs;
    logic [CW:0]   w_sh;
    logic          w_ge;
    logic [CW:0]   w_sub;

    // magnitudes of the operands
    assign w_num_abs = i_num[MW] ? (~i_num + 1'b1) : i_num;
    assign w_den_abs = i_den[CW-1] ? (~i_den + 1'b1) : i_den;

    // one restoring step
    assign w_sh  = {r_rem, r_num[MW-1]};
    assign w_ge  = (w_sh >= {1'b0, r_den});
    assign w_sub = w_sh - {1'b0, r_den};

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && !r_busy && r_fix;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_num_abs[MW-1:0];
            r_den <= w_den_abs;
            r_rem <= '0;
            r_neg <= i_num[MW] ^ i_den[CW-1];
        end else if (r_busy) begin
            r_num <= {r_num[MW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[CW-1:0] : w_sh[CW-1:0];
        end else if (r_fix) begin
            // floor for a negative quotient with a remainder
            if (r_neg)
                r_q <= -($signed({1'b0, r_num}) + $signed({{MW{1'b0}}, (r_rem != '0)}));
            else
                r_q <= $signed({1'b0, r_num});
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hw/rtl/ray_box_closest_hit_table_top.sv =====
// Ray and box closest-hit table: box store, slot sequencer and slab test.
// Depends on rbch_pkg and rbch_div.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request item: add,
//   update, remove or raycast. Output channel o_out_valid / i_out_ready
//   carries one result item per request: status, id and hit distance.
//   One request is worked on at a time; o_in_ready is high whenever the
//   sequencer is idle, even while a finished result waits in the output
//   register.
//   Add, update and remove walk the slots in order. A raycast visits every
//   slot and runs up to six divisions per stored box, two for each axis
//   with a nonzero direction, on the single bit-serial divider; CW is
//   COORD_BITS capped at 32. Reset empties the table and sets the next
//   id to one; no clearing pass. When the receiver stalls, the result is
//   held in the output register and the sequencer waits before writing
//   the next result.
module ray_box_closest_hit_table_top #(
    parameter int MAX_BOXES  = rbch_pkg::DEF_MAX_BOXES,
    parameter int COORD_BITS = rbch_pkg::DEF_COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rbch_pkg::t_req              i_req_type,
    input  logic [rbch_pkg::ID_W-1:0]   i_elem_id,
    input  logic signed [rbch_pkg::IO_W-1:0] i_pos_or_origin_x,
    input  logic signed [rbch_pkg::IO_W-1:0] i_pos_or_origin_y,
    input  logic signed [rbch_pkg::IO_W-1:0] i_pos_or_origin_z,
    input  logic signed [rbch_pkg::IO_W-1:0] i_size_or_dir_x,
    input  logic signed [rbch_pkg::IO_W-1:0] i_size_or_dir_y,
    input  logic signed [rbch_pkg::IO_W-1:0] i_size_or_dir_z,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rbch_pkg::t_status           o_status,
    output logic [rbch_pkg::ID_W-1:0]   o_result_id,
    output logic signed [rbch_pkg::IO_W-1:0] o_hit_distance
);
    import rbch_pkg::*;

    localparam int CW = (COORD_BITS < IO_W) ? COORD_BITS : IO_W;
    localparam int DW = CW + 3;
    localparam int MW = CW + 17;
    localparam int QW = MW + 1;
    localparam int TW = QW + 1;
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int EW = ID_W + 6 * CW;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_AXIS = 4'd3;
    localparam logic [3:0] S_DST  = 4'd4;
    localparam logic [3:0] S_DWT  = 4'd5;
    localparam logic [3:0] S_BOX  = 4'd6;
    localparam logic [3:0] S_NEXT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};

    logic [3:0]      r_state;
    logic [IW-1:0]   r_idx;
    logic [1:0]      r_axis;
    logic            r_half;
    logic [MAX_BOXES-1:0] r_valid;
    logic [ID_W-1:0] r_next_id;

    // latched request
    t_req              r_req_type;
    logic [ID_W-1:0]   r_elem_id;
    logic signed [CW-1:0] r_px, r_py, r_pz, r_sx, r_sy, r_sz;

    // raycast working state
    logic signed [DW-1:0] r_diff;
    logic signed [TW-1:0] r_t1;
    logic signed [TW-1:0] r_lo, r_hi;
    logic signed [TW-1:0] r_best;
    logic [ID_W-1:0]      r_best_id;
    logic                 r_have;

    // result
    t_status         r_status;
    logic [ID_W-1:0] r_rid;
    logic            r_out_valid;
    t_status         r_o_status;
    logic [ID_W-1:0] r_o_rid;
    logic signed [IO_W-1:0] r_o_dist;
    logic            w_out_load;

    // box store
    logic [EW-1:0] mem [MAX_BOXES];
    logic [EW-1:0] r_rd;
    logic          w_we;
    logic [EW-1:0] w_wdata;
    logic [ID_W-1:0] w_rd_id;

    // divider link
    logic                 w_div_start;
    logic                 w_div_done;
    logic signed [QW-1:0] w_div_quo;

    // axis datapath
    logic signed [CW-1:0] w_c, w_s, w_o, w_d;
    logic signed [DW-1:0] w_c2, w_se, w_o2, w_b1, w_b2, w_bmin, w_bmax;
    logic                 w_inside;
    logic signed [TW-1:0] w_t, w_tmin, w_tmax, w_lo_pos;
    logic                 w_hit, w_better, w_match, w_last;
    logic signed [CW-1:0] w_sat;

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign w_rd_id     = r_rd[EW-1 -: ID_W];
    assign w_last      = (r_idx == IW'(MAX_BOXES - 1));
    assign w_match     = r_valid[r_idx] && (w_rd_id == r_elem_id);
    assign w_div_start = (r_state == S_DST);
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // memory write and registered read
    assign w_we = (r_state == S_CHK) &&
        (((r_req_type == REQ_ADD) && !r_valid[r_idx]) ||
         ((r_req_type == REQ_UPD) && w_match));
    assign w_wdata = {((r_req_type == REQ_ADD) ? r_next_id : w_rd_id),
                      r_px, r_py, r_pz, r_sx, r_sy, r_sz};

    always_ff @(posedge i_clk) begin
        if (w_we)
            mem[r_idx] <= w_wdata;
        r_rd <= mem[r_idx];
    end

    // per-axis operand select
    always_comb begin
        case (r_axis)
            AX_X: begin
                w_c = r_rd[6*CW-1 -: CW]; w_s = r_rd[3*CW-1 -: CW];
                w_o = r_px; w_d = r_sx;
            end
            AX_Y: begin
                w_c = r_rd[5*CW-1 -: CW]; w_s = r_rd[2*CW-1 -: CW];
                w_o = r_py; w_d = r_sy;
            end
            default: begin
                w_c = r_rd[4*CW-1 -: CW]; w_s = r_rd[CW-1 -: CW];
                w_o = r_pz; w_d = r_sz;
            end
        endcase
    end

    // slab bounds at doubled scale
    assign w_c2   = $signed({{2{w_c[CW-1]}}, w_c, 1'b0});
    assign w_se   = $signed({{3{w_s[CW-1]}}, w_s});
    assign w_o2   = $signed({{2{w_o[CW-1]}}, w_o, 1'b0});
    assign w_b1   = w_c2 - w_se;
    assign w_b2   = w_c2 + w_se;
    assign w_bmin = (w_b1 < w_b2) ? w_b1 : w_b2;
    assign w_bmax = (w_b1 < w_b2) ? w_b2 : w_b1;
    assign w_inside = !((w_o2 < w_bmin) || (w_o2 > w_bmax));

    // entry and exit of this axis
    assign w_t    = TW'(w_div_quo);
    assign w_tmin = (r_t1 > w_t) ? w_t : r_t1;
    assign w_tmax = (r_t1 > w_t) ? r_t1 : w_t;

    // hit and closest test
    assign w_lo_pos = r_lo[TW-1] ? '0 : r_lo;
    assign w_hit    = (r_hi >= w_lo_pos);
    assign w_better = !r_have || (r_lo < r_best) ||
                      ((r_lo == r_best) && (w_rd_id < r_best_id));

    // saturate the distance
    always_comb begin
        if (r_best > TW'($signed({1'b0, {(CW-1){1'b1}}})))
            w_sat = $signed({1'b0, {(CW-1){1'b1}}});
        else if (r_best < TW'($signed({1'b1, {(CW-1){1'b0}}})))
            w_sat = $signed({1'b1, {(CW-1){1'b0}}});
        else
            w_sat = r_best[CW-1:0];
    end

    rbch_div #(.CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ($signed({r_diff, 15'b0})),
        .i_den   (w_d),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_next_id   <= ID_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            // output register handshake
            if (w_out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if ((i_req_type == REQ_ADD) && (r_next_id == '0))
                            r_state <= S_DONE;
                        else
                            r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    case (r_req_type)
                        REQ_ADD: begin
                            if (!r_valid[r_idx]) begin
                                r_valid[r_idx] <= 1'b1;
                                r_next_id      <= r_next_id + 1'b1;
                                r_state        <= S_DONE;
                            end else begin
                                r_state <= S_NEXT;
                            end
                        end
                        REQ_UPD: r_state <= w_match ? S_DONE : S_NEXT;
                        REQ_REM: begin
                            if (w_match) begin
                                r_valid[r_idx] <= 1'b0;
                                r_state        <= S_DONE;
                            end else begin
                                r_state <= S_NEXT;
                            end
                        end
                        default: r_state <= r_valid[r_idx] ? S_AXIS : S_NEXT;
                    endcase
                end
                S_AXIS: begin
                    if (w_d != '0)
                        r_state <= S_DST;
                    else if (!w_inside)
                        r_state <= S_NEXT;
                    else if (r_axis == AX_Z)
                        r_state <= S_BOX;
                end
                S_DST: r_state <= S_DWT;
                S_DWT: begin
                    if (w_div_done) begin
                        if (r_half && (r_axis == AX_Z))
                            r_state <= S_BOX;
                        else
                            r_state <= S_AXIS;
                    end
                end
                S_BOX: r_state <= S_NEXT;
                S_NEXT: r_state <= w_last ? S_DONE : S_RD;
                S_DONE: begin
                    if (w_out_load)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request, search and result registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req_type <= i_req_type;
                r_elem_id  <= i_elem_id;
                r_px <= i_pos_or_origin_x[CW-1:0];
                r_py <= i_pos_or_origin_y[CW-1:0];
                r_pz <= i_pos_or_origin_z[CW-1:0];
                r_sx <= i_size_or_dir_x[CW-1:0];
                r_sy <= i_size_or_dir_y[CW-1:0];
                r_sz <= i_size_or_dir_z[CW-1:0];
                r_idx     <= '0;
                r_have    <= 1'b0;
                r_best    <= '0;
                r_best_id <= '0;
                r_rid     <= '0;
                r_status  <= (i_req_type == REQ_ADD) ? ST_FULL : ST_OK;
            end
            S_CHK: begin
                r_axis <= AX_X;
                r_half <= 1'b0;
                r_lo   <= T_NEG_INF;
                r_hi   <= T_POS_INF;
                if (r_req_type == REQ_ADD && !r_valid[r_idx]) begin
                    r_status <= ST_OK;
                    r_rid    <= r_next_id;
                end else if ((r_req_type == REQ_UPD || r_req_type == REQ_REM) && w_match) begin
                    r_status <= ST_OK;
                end
            end
            S_AXIS: begin
                if (w_d != '0)
                    r_diff <= (r_half ? w_b2 : w_b1) - w_o2;
                else if (r_axis != AX_Z)
                    r_axis <= r_axis + 1'b1;
            end
            S_DWT: begin
                if (w_div_done) begin
                    if (!r_half) begin
                        r_t1   <= w_t;
                        r_half <= 1'b1;
                    end else begin
                        if (w_tmin > r_lo)
                            r_lo <= w_tmin;
                        if (w_tmax < r_hi)
                            r_hi <= w_tmax;
                        r_half <= 1'b0;
                        if (r_axis != AX_Z)
                            r_axis <= r_axis + 1'b1;
                    end
                end
            end
            S_BOX: begin
                if (w_hit && w_better) begin
                    r_have    <= 1'b1;
                    r_best    <= r_lo;
                    r_best_id <= w_rd_id;
                end
            end
            S_NEXT: begin
                if (w_last) begin
                    case (r_req_type)
                        REQ_ADD: r_status <= ST_FULL;
                        REQ_UPD: r_status <= ST_NFND;
                        REQ_REM: r_status <= ST_NFND;
                        default: begin
                            r_status <= r_have ? ST_OK : ST_NOHIT;
                            r_rid    <= r_have ? r_best_id : '0;
                        end
                    endcase
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    r_o_status <= r_status;
                    r_o_rid    <= r_rid;
                    r_o_dist   <= ((r_req_type == REQ_RAY) && (r_status == ST_OK)) ?
                                  IO_W'(w_sat) : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_result_id    = r_o_rid;
    assign o_hit_distance = r_o_dist;

    // divider only finishes while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWT))
        else $error("divider done outside wait state");

    // a successful add consumes exactly one id
    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && r_req_type == REQ_ADD && !r_valid[r_idx])
        |=> (r_next_id == $past(r_next_id) + 1'b1))
        else $error("id not advanced on add");

    // a raycast hit never reports id zero
    a_hit_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_req_type == REQ_RAY && r_status == ST_OK)
        |-> (r_rid != '0))
        else $error("raycast hit with id zero");

    // no result is written while the sequencer is mid-walk
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for ray_box_closest_hit_table_top: box adds, updates,
// removes and raycasts, checked against a model of the box table.
// Depends on rbch_pkg and the block's RTL.
module tb;
    import rbch_pkg::*;

    // scoreboard: box table model and queue of expected results
    class hit_table_scoreboard;
        typedef struct {
            t_status     st;
            logic [15:0] id;
            logic [31:0] hdist;
        } t_result;

        bit          used [64];
        logic [15:0] ident [64];
        longint      ctr [64][3];
        longint      siz [64][3];
        logic [15:0] next_id;
        t_result     pending [$];
        int          errors;
        int          n_req [4];
        int          n_hits;
        int          n_results;

        function new();
            next_id = 1;
            errors = 0;
            n_hits = 0;
            n_results = 0;
            foreach (used[i]) used[i] = 0;
            foreach (n_req[i]) n_req[i] = 0;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (used[i]) if (used[i]) n++;
            return n;
        endfunction

        function logic [15:0] pick_live();
            int k;
            k = $urandom_range(0, 63);
            for (int j = 0; j < 64; j++)
                if (used[(k + j) % 64]) return ident[(k + j) % 64];
            return 16'd0;
        endfunction

        function int find_slot(logic [15:0] id);
            foreach (used[i]) if (used[i] && ident[i] == id) return i;
            return -1;
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b != 0) && ((a < 0) != (b < 0))) q--;
            return q;
        endfunction

        // narrow the entry/exit window by one axis, 0 on a certain miss
        function bit narrow(longint c, longint s, longint o, longint d,
                            ref longint lo, ref longint hi);
            longint b1, b2, o2, t1, t2, tmp;
            b1 = 2 * c - s;
            b2 = 2 * c + s;
            o2 = 2 * o;
            if (d == 0) begin
                if (b1 > b2) begin
                    tmp = b1; b1 = b2; b2 = tmp;
                end
                return !(o2 < b1 || o2 > b2);
            end
            t1 = fdiv((b1 - o2) * 32768, d);
            t2 = fdiv((b2 - o2) * 32768, d);
            if (t1 > t2) begin
                tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t1 > lo) lo = t1;
            if (t2 < hi) hi = t2;
            return 1;
        endfunction

        function void note_request(t_req req, logic [15:0] id, longint p [3],
                                   longint s [3]);
            t_result r;
            int slot;
            bit have, ok;
            longint best_t, lo, hi, inf;
            logic [15:0] best_id;
            r.st = ST_OK;
            r.id = '0;
            r.hdist = '0;
            n_req[req]++;
            inf = longint'(1) << 62;
            case (req)
                REQ_ADD: begin
                    slot = -1;
                    for (int i = 63; i >= 0; i--) if (!used[i]) slot = i;
                    if (slot < 0 || next_id == 0) r.st = ST_FULL;
                    else begin
                        used[slot] = 1;
                        ident[slot] = next_id;
                        ctr[slot] = p;
                        siz[slot] = s;
                        r.id = next_id;
                        next_id++;
                    end
                end
                REQ_UPD: begin
                    slot = find_slot(id);
                    if (slot < 0) r.st = ST_NFND;
                    else begin
                        ctr[slot] = p;
                        siz[slot] = s;
                    end
                end
                REQ_REM: begin
                    slot = find_slot(id);
                    if (slot < 0) r.st = ST_NFND;
                    else used[slot] = 0;
                end
                default: begin
                    have = 0;
                    best_t = 0;
                    best_id = 0;
                    for (int i = 0; i < 64; i++) begin
                        if (!used[i]) continue;
                        lo = -inf;
                        hi = inf;
                        ok = narrow(ctr[i][0], siz[i][0], p[0], s[0], lo, hi);
                        ok = ok && narrow(ctr[i][1], siz[i][1], p[1], s[1], lo, hi);
                        ok = ok && narrow(ctr[i][2], siz[i][2], p[2], s[2], lo, hi);
                        if (!ok || hi < (lo > 0 ? lo : 0)) continue;
                        if (!have || lo < best_t || (lo == best_t && ident[i] < best_id)) begin
                            have = 1;
                            best_t = lo;
                            best_id = ident[i];
                        end
                    end
                    if (have) begin
                        // clamp to the signed 32-bit range
                        if (best_t > 64'sd2147483647) best_t = 64'sd2147483647;
                        if (best_t < -64'sd2147483648) best_t = -64'sd2147483648;
                        r.hdist = best_t[31:0];
                        r.id = best_id;
                        n_hits++;
                    end else r.st = ST_NOHIT;
                end
            endcase
            pending = {pending, r};
        endfunction

        function void check_result(t_status st, logic [15:0] id, logic [31:0] hit_dist);
            t_result e;
            n_results++;
            if (pending.size() == 0) begin
                $error("result with nothing expected: status %0d id %0d", st, id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.st) begin
                $error("status: expected %0d actual %0d", e.st, st);
                errors++;
            end
            if (id !== e.id) begin
                $error("result_id: expected %0d actual %0d", e.id, id);
                errors++;
            end
            if (hit_dist !== e.hdist) begin
                $error("hit_distance: expected %h actual %h", e.hdist, hit_dist);
                errors++;
            end
        endfunction
    endclass

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    t_req        i_req_type = REQ_ADD;
    logic [15:0] i_elem_id = '0;
    logic signed [31:0] i_pos_or_origin_x = '0, i_pos_or_origin_y = '0;
    logic signed [31:0] i_pos_or_origin_z = '0;
    logic signed [31:0] i_size_or_dir_x = '0, i_size_or_dir_y = '0, i_size_or_dir_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    t_status     o_status;
    logic [15:0] o_result_id;
    logic signed [31:0] o_hit_distance;

    hit_table_scoreboard sb = new();
    int     max_gap = 9;
    longint cycles = 0;

    ray_box_closest_hit_table_top dut (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_box_closest_hit_table_top regression: fail");
            $finish;
        end
    end

    // send one request item, starting and ending at a falling edge
    task automatic send(t_req r, logic [15:0] id, logic [31:0] ax, logic [31:0] ay,
                        logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                        logic [31:0] bz);
        int gap;
        longint p [3];
        longint s [3];
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type = r;
        i_elem_id = id;
        i_pos_or_origin_x = ax;
        i_pos_or_origin_y = ay;
        i_pos_or_origin_z = az;
        i_size_or_dir_x = bx;
        i_size_or_dir_y = by;
        i_size_or_dir_z = bz;
        i_in_valid = 1;
        do @(posedge i_clk); while (!o_in_ready);
        p = '{$signed(ax), $signed(ay), $signed(az)};
        s = '{$signed(bx), $signed(by), $signed(bz)};
        sb.note_request(r, id, p, s);
        @(negedge i_clk);
    endtask

    // receiver: random stall per item, then check on acceptance
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, max_gap);
            if (stall > 0) begin
                i_out_ready = 0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_status, o_result_id, o_hit_distance);
        end
    end

    // value within +-8.0
    function automatic logic [31:0] near_val();
        return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
    endfunction

    function automatic logic [31:0] any_val();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h0;
            default: return near_val();
        endcase
    endfunction

    function automatic logic [31:0] box_size();
        case ($urandom_range(0, 9))
            0: return any_val();
            1: return -$urandom_range(32'h8000, 32'h4_0000);
            default: return $urandom_range(32'h8000, 32'h8_0000);
        endcase
    endfunction

    function automatic logic [31:0] ray_dir();
        case ($urandom_range(0, 9))
            0, 1: return 32'h0;
            2: return any_val();
            default: return near_val();
        endcase
    endfunction

    task automatic add_box();
        send(REQ_ADD, 16'($urandom()), near_val(), near_val(), near_val(),
             box_size(), box_size(), box_size());
    endtask

    task automatic cast_ray();
        send(REQ_RAY, 16'($urandom()), near_val(), near_val(), near_val(),
             ray_dir(), ray_dir(), ray_dir());
    endtask

    task automatic clear_table();
        while (sb.live_count() > 0) send(REQ_REM, sb.pick_live(), 0, 0, 0, 0, 0, 0);
    endtask

    initial begin
        logic [15:0] id;
        int pick;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty table, unknown ids
        send(REQ_RAY, 16'd0, 0, 0, 0, ONE, 0, 0);
        send(REQ_UPD, 16'd0, 0, 0, 0, ONE, ONE, ONE);
        send(REQ_REM, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        // box of side two centred at the origin and a twin for the tie rule
        send(REQ_ADD, 16'd0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE);
        send(REQ_ADD, 16'd0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE);
        send(REQ_RAY, 16'd0, -10 * ONE, 0, 0, ONE, 0, 0);
        send(REQ_RAY, 16'd0, 0, 0, 0, 0, -ONE, 0);
        // zero direction with origin outside the slab
        send(REQ_RAY, 16'd0, -10 * ONE, 5 * ONE, 0, ONE, 0, 0);
        // all direction zero, origin inside
        send(REQ_RAY, 16'd0, ONE >> 1, 0, 0, 0, 0, 0);
        // tiny direction gives a distance past the positive limit
        send(REQ_RAY, 16'd0, 32'h8000_0000, 0, 0, 32'h1, 0, 0);
        send(REQ_REM, 16'd1, 0, 0, 0, 0, 0, 0);
        send(REQ_REM, 16'd1, 0, 0, 0, 0, 0, 0);
        // negative sizes, then extreme values
        send(REQ_UPD, 16'd2, ONE, 0, 0, -2 * ONE, -ONE, -ONE);
        send(REQ_RAY, 16'd0, 5 * ONE, 0, 0, -ONE, 0, 0);
        send(REQ_UPD, 16'd2, 32'h7FFF_FFFF, 32'h8000_0000, 0,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send(REQ_RAY, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        send(REQ_RAY, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);

        // fill the table, overflow it, one full-table raycast, then empty it
        while (sb.live_count() < 64) add_box();
        send(REQ_ADD, 16'd0, 0, 0, 0, ONE, ONE, ONE);
        cast_ray();
        clear_table();

        // random mix, small tables most of the time
        for (int n = 0; n < 1800; n++) begin
            if (n % 300 == 150) max_gap = 0;
            if (n % 300 == 0) max_gap = 9;
            pick = $urandom_range(0, 99);
            if (pick < 35 && sb.live_count() < 5) add_box();
            else if (pick < 50) begin
                id = ($urandom_range(0, 3) != 0) ? sb.pick_live() : 16'($urandom());
                send(REQ_UPD, id, near_val(), near_val(), near_val(),
                     box_size(), box_size(), box_size());
            end else if (pick < 62) begin
                id = ($urandom_range(0, 3) != 0) ? sb.pick_live() : 16'($urandom());
                send(REQ_REM, id, any_val(), any_val(), any_val(),
                     any_val(), any_val(), any_val());
            end else if (pick < 66) begin
                send(pick[0] ? REQ_ADD : REQ_RAY, 16'($urandom()), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom());
            end else cast_ray();
        end

        // one more add and raycast after the mix
        send(REQ_ADD, 16'd0, 0, 0, 0, ONE, ONE, ONE);
        cast_ray();
        i_in_valid = 0;

        // drain and finish
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d adds, %0d updates, %0d removes, %0d raycasts (%0d hits)",
                 sb.n_req[REQ_ADD], sb.n_req[REQ_UPD], sb.n_req[REQ_REM],
                 sb.n_req[REQ_RAY], sb.n_hits);
        $display("checked %0d results, full table and overflow included", sb.n_results);
        if (sb.errors == 0)
            $display("ray_box_closest_hit_table_top regression: pass");
        else
            $display("ray_box_closest_hit_table_top regression: fail");
        $finish;
    end
endmodule
